/* rtl/has_pkg.sv */
// Package for the handle array store: field widths, command, status and state codes.
package has_pkg;

    // Fixed field widths of the stream payload
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int HANDLE_W  = 9;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 144;   // 137 payload bits padded to bytes
    localparam int M_TDATA_W = 120;   // 114 payload bits padded to bytes

    // Command codes carried in s tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_DEFINE = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_PUT    = 3'd2,
        CMD_GET    = 3'd3,
        CMD_LIMITS = 3'd4,
        CMD_STATS  = 3'd5
    } t_cmd;

    // Status codes carried in m tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_LIMITS = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_BAD_HANDLE = 3'd3,
        ST_INACTIVE   = 3'd4,
        ST_BAD_INDEX  = 3'd5
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEF_CHK,
        S_FILL,
        S_HCHK,
        S_IDX1,
        S_IDX2,
        S_RD,
        S_RESP
    } t_state;

endpackage

/* rtl/handle_array_store_top.sv */
// Top level of the handle array store: sequencer, handle tables and free stack.
//
// Usage: commands enter on the s channel (tvalid/tready/tdata/tuser), one
// item at a time; tuser holds the command code. Every command gives exactly
// one result item on the m channel; tuser holds the status code.
// The block takes a new item only while its sequencer is idle. A shared
// 33-bit subtractor does all limit and index checks, one per cycle.
// Steps from accept to the response state, which loads the output register:
//   define ok:       decode, limit check, fill (one element write per cycle)
//   define failing:  decode, limit check
//   free:            decode, and a handle check for a valid nonzero handle
//   put, get:        decode, handle check, lower and upper index check; get adds a read
//   get limits:      decode, handle check; stats and unused codes: decode only
// The fill of a new array through the single element memory port makes a
// successful define the longest command.
// Reset: synchronous, active low. All handles become free, handle 1 is
// given out first; the free stack needs no clearing pass. Bounds and
// element memory are undefined until a define writes them.
// A stalled receiver holds the result in the output register; the block
// still accepts and works on the next item, and waits only when a second
// result is ready before the first one was taken.
module handle_array_store_top
    import has_pkg::*;
#(
    parameter int NUM_HANDLES = 256,
    parameter int MAX_LEN     = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // handle_in[8:0], elem_index[40:9], data_in[72:41], lower_limit[104:73],
    // upper_limit[136:105], zero pad
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // cmd[2:0]
    input  logic [CMD_W-1:0]     i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // handle_out[8:0], data_out[40:9], lower_out[72:41], upper_out[104:73],
    // free_count[113:105], zero pad
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]  o_m_tuser
);

    localparam int SW = $clog2(NUM_HANDLES);
    localparam int TW = $clog2(NUM_HANDLES + 1);
    localparam int OW = $clog2(MAX_LEN + 1);
    localparam int DEPTH = NUM_HANDLES * MAX_LEN;
    localparam int AW = $clog2(DEPTH);

    // control state
    t_state                r_state, n_state;
    logic [TW-1:0]         r_top, n_top;
    logic [TW-1:0]         r_min_top, n_min_top;
    logic [NUM_HANDLES-1:0] r_active, n_active;
    logic                  r_m_valid, n_m_valid;

    // item registers
    t_cmd                  r_cmd, n_cmd;
    logic [HANDLE_W-1:0]   r_h, n_h;
    logic signed [WORD_W-1:0] r_idx, n_idx;
    logic [WORD_W-1:0]     r_data, n_data;
    logic signed [WORD_W-1:0] r_lo, n_lo;
    logic signed [WORD_W-1:0] r_hi, n_hi;

    // working registers
    logic signed [WORD_W:0] r_acc, n_acc;
    logic [SW-1:0]         r_slot, n_slot;
    logic [AW-1:0]         r_base;
    logic [OW-1:0]         r_off, n_off;
    logic [OW-1:0]         r_cnt, n_cnt;

    // result under construction
    t_status               r_res_status, n_res_status;
    logic [HANDLE_W-1:0]   r_res_hout, n_res_hout;
    logic [WORD_W-1:0]     r_res_dout, n_res_dout;
    logic [WORD_W-1:0]     r_res_lout, n_res_lout;
    logic [WORD_W-1:0]     r_res_uout, n_res_uout;
    logic [COUNT_W-1:0]    r_res_fcnt, n_res_fcnt;

    // output register
    t_status               r_m_status, n_m_status;
    logic [HANDLE_W-1:0]   r_m_hout, n_m_hout;
    logic [WORD_W-1:0]     r_m_dout, n_m_dout;
    logic [WORD_W-1:0]     r_m_lout, n_m_lout;
    logic [WORD_W-1:0]     r_m_uout, n_m_uout;
    logic [COUNT_W-1:0]    r_m_fcnt, n_m_fcnt;

    // free stack and bounds tables
    logic [SW-1:0]         stack_mem [NUM_HANDLES];
    logic [SW-1:0]         r_stack_rdata;
    logic [WORD_W-1:0]     lo_mem [NUM_HANDLES];
    logic [WORD_W-1:0]     hi_mem [NUM_HANDLES];
    logic signed [WORD_W-1:0] r_lo_rdata, r_hi_rdata;

    logic                  stack_we;
    logic [SW-1:0]         stack_raddr;
    logic                  bnd_we;
    logic [SW-1:0]         h_slot;

    // shared subtractor
    logic signed [WORD_W:0] sub_a, sub_b, sub_y;

    // element memory port
    logic                  elem_we, elem_re;
    logic [AW-1:0]         elem_addr;
    logic [WORD_W-1:0]     elem_rdata;

    logic                  s_fire;
    logic                  h_bad;
    logic [SW-1:0]         pop_slot;
    logic                  out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    assign h_slot      = SW'(r_h - HANDLE_W'(1));
    assign stack_raddr = SW'(r_top - TW'(1));
    assign h_bad       = (r_h == '0) || (32'(r_h) > 32'(NUM_HANDLES));
    assign sub_y       = sub_a - sub_b;

    // popped slot: entries below the lowest top ever reached were never written, so their initial value is computed
    assign pop_slot = (stack_raddr >= SW'(r_min_top)) && (r_top > r_min_top) ?
                      r_stack_rdata : SW'(NUM_HANDLES - 1) - stack_raddr;

    assign elem_addr = r_base + ((r_state == S_FILL) ? AW'(r_cnt) : AW'(r_off));

    // sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_min_top    = r_min_top;
        n_active     = r_active;
        n_m_valid    = r_m_valid;
        n_cmd        = r_cmd;
        n_h          = r_h;
        n_idx        = r_idx;
        n_data       = r_data;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_acc        = r_acc;
        n_slot       = r_slot;
        n_off        = r_off;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_hout   = r_res_hout;
        n_res_dout   = r_res_dout;
        n_res_lout   = r_res_lout;
        n_res_uout   = r_res_uout;
        n_res_fcnt   = r_res_fcnt;
        n_m_status   = r_m_status;
        n_m_hout     = r_m_hout;
        n_m_dout     = r_m_dout;
        n_m_lout     = r_m_lout;
        n_m_uout     = r_m_uout;
        n_m_fcnt     = r_m_fcnt;
        stack_we     = 1'b0;
        bnd_we       = 1'b0;
        elem_we      = 1'b0;
        elem_re      = 1'b0;
        sub_a        = 33'(r_hi);
        sub_b        = 33'(r_lo);

        // result taken by the receiver
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_cmd        = t_cmd'(i_s_tuser);
                    n_h          = i_s_tdata[8:0];
                    n_idx        = i_s_tdata[40:9];
                    n_data       = i_s_tdata[72:41];
                    n_lo         = i_s_tdata[104:73];
                    n_hi         = i_s_tdata[136:105];
                    n_res_status = ST_OK;
                    n_res_hout   = '0;
                    n_res_dout   = '0;
                    n_res_lout   = '0;
                    n_res_uout   = '0;
                    n_res_fcnt   = '0;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_acc  = sub_y;
                n_slot = h_slot;
                case (r_cmd)
                    CMD_DEFINE: begin
                        n_state = S_DEF_CHK;
                    end
                    CMD_FREE: begin
                        if (r_h == '0) begin
                            n_state = S_RESP;
                        end else if (h_bad) begin
                            n_res_status = ST_BAD_HANDLE;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_HCHK;
                        end
                    end
                    CMD_PUT, CMD_GET, CMD_LIMITS: begin
                        if (h_bad) begin
                            n_res_status = ST_BAD_HANDLE;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_HCHK;
                        end
                    end
                    CMD_STATS: begin
                        n_res_fcnt = COUNT_W'(r_top);
                        n_state    = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            // define: limit check and handle pop
            S_DEF_CHK: begin
                if (r_acc < 0) begin
                    n_res_status = ST_BAD_LIMITS;
                    n_state      = S_RESP;
                end else if (r_acc >= 33'(MAX_LEN) || r_top == '0) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_RESP;
                end else begin
                    n_slot           = pop_slot;
                    n_top            = r_top - TW'(1);
                    if (n_top < r_min_top) begin
                        n_min_top = n_top;
                    end
                    bnd_we           = 1'b1;
                    n_active[pop_slot] = 1'b1;
                    n_res_hout       = HANDLE_W'(32'(pop_slot) + 32'd1);
                    n_cnt            = '0;
                    n_state          = S_FILL;
                end
            end
            // define: one element write per cycle
            S_FILL: begin
                elem_we = 1'b1;
                if (r_cnt == OW'(r_acc)) begin
                    n_state = S_RESP;
                end else begin
                    n_cnt = r_cnt + OW'(1);
                end
            end
            // handle in use check and per-command action
            S_HCHK: begin
                if (!r_active[r_slot]) begin
                    n_res_status = ST_INACTIVE;
                    n_state      = S_RESP;
                end else begin
                    case (r_cmd)
                        CMD_FREE: begin
                            n_active[r_slot] = 1'b0;
                            if (32'(r_top) < 32'(NUM_HANDLES)) begin
                                stack_we = 1'b1;
                                n_top    = r_top + TW'(1);
                            end
                            n_state = S_RESP;
                        end
                        CMD_LIMITS: begin
                            n_res_lout = r_lo_rdata;
                            n_res_uout = r_hi_rdata;
                            n_state    = S_RESP;
                        end
                        default: begin
                            sub_a   = 33'(r_idx);
                            sub_b   = 33'(r_lo_rdata);
                            n_acc   = sub_y;
                            n_state = S_IDX1;
                        end
                    endcase
                end
            end
            // index at or above lower limit, offset inside the slot
            S_IDX1: begin
                if (r_acc < 0 || r_acc >= 33'(MAX_LEN)) begin
                    n_res_status = ST_BAD_INDEX;
                    n_state      = S_RESP;
                end else begin
                    n_off   = OW'(r_acc);
                    sub_a   = 33'(r_hi_rdata);
                    sub_b   = 33'(r_idx);
                    n_acc   = sub_y;
                    n_state = S_IDX2;
                end
            end
            // index at or below upper limit, then access
            S_IDX2: begin
                if (r_acc < 0) begin
                    n_res_status = ST_BAD_INDEX;
                    n_state      = S_RESP;
                end else if (r_cmd == CMD_PUT) begin
                    elem_we = 1'b1;
                    n_state = S_RESP;
                end else begin
                    elem_re = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_res_dout = elem_rdata;
                n_state    = S_RESP;
            end
            // hand the result to the output register
            S_RESP: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_hout   = r_res_hout;
                    n_m_dout   = r_res_dout;
                    n_m_lout   = r_res_lout;
                    n_m_uout   = r_res_uout;
                    n_m_fcnt   = r_res_fcnt;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= TW'(NUM_HANDLES);
            r_min_top <= TW'(NUM_HANDLES);
            r_active  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_min_top <= n_min_top;
            r_active  <= n_active;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers; the slot base address follows the slot register
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_h          <= n_h;
        r_idx        <= n_idx;
        r_data       <= n_data;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_acc        <= n_acc;
        r_slot       <= n_slot;
        r_base       <= AW'(n_slot) * AW'(MAX_LEN);
        r_off        <= n_off;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_hout   <= n_res_hout;
        r_res_dout   <= n_res_dout;
        r_res_lout   <= n_res_lout;
        r_res_uout   <= n_res_uout;
        r_res_fcnt   <= n_res_fcnt;
        r_m_status   <= n_m_status;
        r_m_hout     <= n_m_hout;
        r_m_dout     <= n_m_dout;
        r_m_lout     <= n_m_lout;
        r_m_uout     <= n_m_uout;
        r_m_fcnt     <= n_m_fcnt;
    end

    // free stack memory: push at top, read below top
    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[SW'(r_top)] <= r_slot;
        end
        r_stack_rdata <= stack_mem[stack_raddr];
    end

    // bounds tables, read at the handle's slot
    always_ff @(posedge i_clk) begin
        if (bnd_we) begin
            lo_mem[pop_slot] <= r_lo;
            hi_mem[pop_slot] <= r_hi;
        end
        r_lo_rdata <= lo_mem[h_slot];
        r_hi_rdata <= hi_mem[h_slot];
    end

    has_elem_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WORD_W)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_re    (elem_re),
        .i_addr  (elem_addr),
        .i_wdata (r_data),
        .o_rdata (elem_rdata)
    );

    // output packing
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {6'd0, r_m_fcnt, r_m_uout, r_m_lout, r_m_dout, r_m_hout};

endmodule

/* rtl/has_elem_ram.sv */
// Single-port element memory with registered read data.
module has_elem_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write and registered read on one port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
